// ===== hdl/ils_pkg.sv =====
// ils_pkg: operation and status codes, stream widths and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none

package ils_pkg;

  localparam int FUNC_BITS   = 3;
  localparam int POS_BITS    = 6;
  localparam int VALUE_BITS  = 32;
  localparam int COUNT_BITS  = 7;
  localparam int STATUS_BITS = 2;
  localparam int TDATA_BITS  = 48;

  localparam logic [FUNC_BITS-1:0] FN_APPEND = 3'd0;
  localparam logic [FUNC_BITS-1:0] FN_REMOVE = 3'd1;
  localparam logic [FUNC_BITS-1:0] FN_INSERT = 3'd2;
  localparam logic [FUNC_BITS-1:0] FN_ERASE  = 3'd3;
  localparam logic [FUNC_BITS-1:0] FN_READ   = 3'd4;
  localparam logic [FUNC_BITS-1:0] FN_CLEAR  = 3'd5;

  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_BAD   = 2'd3;

  typedef struct packed {
    logic load_in;
    logic set_status;
    logic wr_app;
    logic wr_pos;
    logic inc_used;
    logic dec_used;
    logic clr_used;
    logic rd_pos;
    logic rd_ins_start;
    logic rd_ers_start;
    logic shift_up;
    logic shift_dn;
    logic take_read;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_BITS-1:0]   func;
    logic [STATUS_BITS-1:0] code;
    logic                   ins_tail;
    logic                   ers_tail;
    logic                   up_end;
    logic                   dn_end;
    logic                   out_busy;
  } stat_t;

endpackage

`default_nettype wire

// ===== hdl/ils_dp.sv =====
// ils_dp: list datapath - entry memory, fill count, shift pointer,
// status decode and output register. Depends on ils_pkg.
`default_nettype none

module ils_dp
  import ils_pkg::*;
#(
  parameter int CAPACITY  = 64,
  parameter int WORD_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [TDATA_BITS-1:0] s_tdata,
  input  wire logic                  m_tready,
  output logic                       m_tvalid,
  output logic [TDATA_BITS-1:0]      m_tdata,
  input  wire cmd_t                  cmd,
  output stat_t                      stat
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_BITS) ? CNT_W : POS_BITS;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam int PAD_W = TDATA_BITS - VALUE_BITS - COUNT_BITS - STATUS_BITS;

  logic [WORD_BITS-1:0] mem [CAPACITY];

  logic [FUNC_BITS-1:0]   func;
  logic [CMP_W-1:0]       pos;
  logic [WORD_BITS-1:0]   word;
  logic [CNT_W-1:0]       used;
  logic [IDX_W-1:0]       ptr;
  logic [WORD_BITS-1:0]   rdata;
  logic [STATUS_BITS-1:0] status;
  logic [VALUE_BITS-1:0]  rv;

  logic [IDX_W-1:0]       pos_a;
  logic [CNT_W-1:0]       used_m1;
  logic [CMP_W-1:0]       used_c;
  logic                   empty;
  logic                   full;
  logic [STATUS_BITS-1:0] code;
  logic                   we;
  logic [IDX_W-1:0]       waddr;
  logic [WORD_BITS-1:0]   wdata;
  logic                   re;
  logic [IDX_W-1:0]       raddr;

  assign pos_a   = pos[IDX_W-1:0];
  assign used_m1 = used - CNT_W'(1);
  assign used_c  = CMP_W'(used);
  assign empty   = (used == '0);
  assign full    = (used == CAP_CNT);

  always_comb begin
    code = ST_OK;
    case (func)
      FN_APPEND: code = full ? ST_FULL : ST_OK;
      FN_REMOVE: code = empty ? ST_EMPTY : ST_OK;
      FN_INSERT: begin
        if (full) code = ST_FULL;
        else if (pos > used_c) code = ST_BAD;
      end
      FN_ERASE, FN_READ: begin
        if (empty) code = ST_EMPTY;
        else if (pos >= used_c) code = ST_BAD;
      end
      default: code = ST_OK;
    endcase
  end

  assign stat.func     = func;
  assign stat.code     = code;
  assign stat.ins_tail = (pos == used_c);
  assign stat.ers_tail = (pos == CMP_W'(used_m1));
  assign stat.up_end   = (ptr == pos_a);
  assign stat.dn_end   = (CNT_W'(ptr) == used_m1);
  assign stat.out_busy = m_tvalid;

  always_comb begin
    we    = 1'b0;
    waddr = pos_a;
    wdata = word;
    if (cmd.wr_app) begin
      we    = 1'b1;
      waddr = used[IDX_W-1:0];
    end else if (cmd.wr_pos) begin
      we    = 1'b1;
    end else if (cmd.shift_up) begin
      we    = 1'b1;
      waddr = ptr + IDX_W'(1);
      wdata = rdata;
    end else if (cmd.shift_dn) begin
      we    = 1'b1;
      waddr = ptr - IDX_W'(1);
      wdata = rdata;
    end
  end

  always_comb begin
    re    = 1'b0;
    raddr = pos_a;
    if (cmd.rd_pos) begin
      re    = 1'b1;
    end else if (cmd.rd_ins_start) begin
      re    = 1'b1;
      raddr = used_m1[IDX_W-1:0];
    end else if (cmd.rd_ers_start) begin
      re    = 1'b1;
      raddr = pos_a + IDX_W'(1);
    end else if (cmd.shift_up && !stat.up_end) begin
      re    = 1'b1;
      raddr = ptr - IDX_W'(1);
    end else if (cmd.shift_dn && !stat.dn_end) begin
      re    = 1'b1;
      raddr = ptr + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func <= s_tdata[FUNC_BITS-1:0];
      pos  <= CMP_W'(s_tdata[FUNC_BITS +: POS_BITS]);
      word <= WORD_BITS'(s_tdata[FUNC_BITS+POS_BITS +: VALUE_BITS]);
    end
    if (cmd.rd_ins_start) ptr <= used_m1[IDX_W-1:0];
    else if (cmd.rd_ers_start) ptr <= pos_a + IDX_W'(1);
    else if (cmd.shift_up) ptr <= ptr - IDX_W'(1);
    else if (cmd.shift_dn) ptr <= ptr + IDX_W'(1);
    if (cmd.set_status) begin
      status <= code;
      rv     <= '0;
    end else if (cmd.take_read) begin
      rv <= VALUE_BITS'($signed(rdata));
    end
    if (cmd.out_load) m_tdata <= {PAD_W'(0), status, COUNT_BITS'(used), rv};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.clr_used) used <= '0;
      else if (cmd.inc_used) used <= used + CNT_W'(1);
      else if (cmd.dec_used) used <= used_m1;
      if (cmd.out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ils_ctrl.sv =====
// ils_ctrl: sequencing state machine for the list operations and the
// entry shifts. Depends on ils_pkg.
`default_nettype none

module ils_ctrl
  import ils_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  s_tvalid,
  output logic       s_tready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EXEC = 7'b0000010,
    S_SHUP = 7'b0000100,
    S_PUT  = 7'b0001000,
    S_SHDN = 7'b0010000,
    S_RDW  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   ok;

  assign s_tready = (state == S_IDLE);
  assign ok       = (stat.code == ST_OK);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.set_status = 1'b1;
        state_next     = S_FIN;
        case (stat.func)
          FN_APPEND: begin
            cmd.wr_app   = ok;
            cmd.inc_used = ok;
          end
          FN_REMOVE: cmd.dec_used = ok;
          FN_INSERT: begin
            if (ok && stat.ins_tail) begin
              cmd.wr_pos   = 1'b1;
              cmd.inc_used = 1'b1;
            end else if (ok) begin
              cmd.rd_ins_start = 1'b1;
              state_next       = S_SHUP;
            end
          end
          FN_ERASE: begin
            if (ok && stat.ers_tail) begin
              cmd.dec_used = 1'b1;
            end else if (ok) begin
              cmd.rd_ers_start = 1'b1;
              state_next       = S_SHDN;
            end
          end
          FN_READ: begin
            if (ok) begin
              cmd.rd_pos = 1'b1;
              state_next = S_RDW;
            end
          end
          FN_CLEAR: cmd.clr_used = 1'b1;
          default: ;
        endcase
      end
      S_SHUP: begin
        cmd.shift_up = 1'b1;
        if (stat.up_end) state_next = S_PUT;
      end
      S_PUT: begin
        cmd.wr_pos   = 1'b1;
        cmd.inc_used = 1'b1;
        state_next   = S_FIN;
      end
      S_SHDN: begin
        cmd.shift_dn = 1'b1;
        if (stat.dn_end) begin
          cmd.dec_used = 1'b1;
          state_next   = S_FIN;
        end
      end
      S_RDW: begin
        cmd.take_read = 1'b1;
        state_next    = S_FIN;
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

`default_nettype wire

// ===== hdl/indexed_list_store.sv =====
// indexed_list_store: top level of the ordered word list with indexed
// insert and erase. Depends on ils_pkg, ils_ctrl and ils_dp.
//
//   channel | direction | tdata fields (low bit up)
//   s_*     | in        | func[2:0] position[8:3] value[40:9], zero pad to 48
//   m_*     | out       | read_value[31:0] count[38:32] status[40:39], pad to 48
//
// One item at a time: execute, then finish; a read adds a read-wait step,
// an insert below the tail a shift-up and a put step, an erase before the
// last entry a shift-down step, one memory entry moved per cycle through the
// single read port and write port. Reset clears the count and the output
// valid flag; the entry memory is not cleared. A result not yet taken holds
// the block in its final step before the next result is loaded; the next
// item is accepted after that load.
`default_nettype none

module indexed_list_store
  import ils_pkg::*;
#(
  parameter int CAPACITY  = 64,
  parameter int WORD_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [TDATA_BITS-1:0] s_tdata,   // func, position, value
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [TDATA_BITS-1:0]      m_tdata    // read_value, count, status
);

  cmd_t  cmd;
  stat_t stat;

  ils_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ils_dp #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

`default_nettype wire

// ===== bench/tb_indexed_list_store.sv =====
// Self-checking bench for indexed_list_store: directed and random list operations on the
// stream ports, predicted by an in-bench list tracker and checked item by item.
// Depends on ils_pkg and the indexed_list_store RTL.
module tb_indexed_list_store
  import ils_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH   = 64;
  localparam int RANDOM_ITEMS = 830;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 80;

  localparam logic [FUNC_BITS-1:0] FN_SPARE_LO = 3'd6;
  localparam logic [FUNC_BITS-1:0] FN_SPARE_HI = 3'd7;

  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} mix_mode_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0]  read_value;
    logic [COUNT_BITS-1:0]  count;
    logic [STATUS_BITS-1:0] status;
  } reply_t;

  class list_tracker;
    logic [VALUE_BITS-1:0] words [LIST_DEPTH];
    int     used;
    reply_t pending_replies [$];
    int     errors, n_checked, n_full, n_empty, n_bad, peak_used;

    function new();
      used = 0;
      errors = 0;
      n_checked = 0;
      n_full = 0;
      n_empty = 0;
      n_bad = 0;
      peak_used = 0;
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction

    function reply_t apply_op(logic [FUNC_BITS-1:0] fn, logic [POS_BITS-1:0] pos,
                              logic [VALUE_BITS-1:0] val);
      reply_t r;
      int j;
      r = '0;
      r.status = ST_OK;
      case (fn)
        FN_APPEND: begin
          if (used >= LIST_DEPTH) r.status = ST_FULL;
          else begin
            words[used] = val;
            used++;
          end
        end
        FN_REMOVE: begin
          if (used == 0) r.status = ST_EMPTY;
          else used--;
        end
        FN_INSERT: begin
          if (used >= LIST_DEPTH) r.status = ST_FULL;
          else if (int'(pos) > used) r.status = ST_BAD;
          else begin
            for (j = used; j > int'(pos); j--) words[j] = words[j-1];
            words[pos] = val;
            used++;
          end
        end
        FN_ERASE: begin
          if (used == 0) r.status = ST_EMPTY;
          else if (int'(pos) >= used) r.status = ST_BAD;
          else begin
            for (j = int'(pos); j + 1 < used; j++) words[j] = words[j+1];
            used--;
          end
        end
        FN_READ: begin
          if (used == 0) r.status = ST_EMPTY;
          else if (int'(pos) >= used) r.status = ST_BAD;
          else r.read_value = words[pos];
        end
        FN_CLEAR: used = 0;
        default: ;
      endcase
      r.count = used[COUNT_BITS-1:0];
      return r;
    endfunction

    function void note_item(logic [TDATA_BITS-1:0] d);
      reply_t r;
      r = apply_op(d[2:0], d[8:3], d[40:9]);
      if (used > peak_used) peak_used = used;
      case (r.status)
        ST_FULL:  n_full++;
        ST_EMPTY: n_empty++;
        ST_BAD:   n_bad++;
        default: ;
      endcase
      pending_replies = {pending_replies, r};
    endfunction

    function void check_item(logic [TDATA_BITS-1:0] d);
      reply_t exp_r, act_r;
      act_r.read_value = d[31:0];
      act_r.count      = d[38:32];
      act_r.status     = d[40:39];
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected item on m_tdata: %h", $time, d);
        errors++;
        return;
      end
      exp_r = pending_replies.pop_front();
      n_checked++;
      if (act_r.read_value !== exp_r.read_value) begin
        $display("%0t: read_value mismatch: expected %h, got %h",
                 $time, exp_r.read_value, act_r.read_value);
        errors++;
      end
      if (act_r.count !== exp_r.count) begin
        $display("%0t: count mismatch: expected %0d, got %0d", $time, exp_r.count, act_r.count);
        errors++;
      end
      if (act_r.status !== exp_r.status) begin
        $display("%0t: status mismatch: expected %0d, got %0d",
                 $time, exp_r.status, act_r.status);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [TDATA_BITS-1:0] s_tdata = '0;   // func[2:0] position[8:3] value[40:9], pad
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [TDATA_BITS-1:0] m_tdata;        // read_value[31:0] count[38:32] status[40:39], pad

  list_tracker tracker = new();
  int send_idle = 0;
  int recv_stall = 0;
  bit hold_req = 1'b0;

  indexed_list_store uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver: random stalls, or a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_item(m_tdata);
  end

  task automatic send_item(input logic [TDATA_BITS-1:0] d);
    if ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.note_item(d);
  endtask

  task automatic send_op(input logic [FUNC_BITS-1:0] fn, input logic [POS_BITS-1:0] pos,
                         input logic [VALUE_BITS-1:0] val);
    send_item({7'd0, val, pos, fn});
  endtask

  task automatic drain_replies();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  function automatic logic [TDATA_BITS-1:0] pick_item(mix_mode_t mode);
    logic [FUNC_BITS-1:0]  fn;
    logic [POS_BITS-1:0]   pos;
    logic [VALUE_BITS-1:0] val;
    int r, t_app, t_ins, t_rd, t_ers, t_rem, t_clr;
    case (mode)
      MODE_GROW:   begin t_app = 35; t_ins = 70; t_rd = 85; t_ers = 92; t_rem = 97; t_clr = 98; end
      MODE_SHRINK: begin t_app = 10; t_ins = 20; t_rd = 40; t_ers = 70; t_rem = 95; t_clr = 97; end
      default:     begin t_app = 20; t_ins = 40; t_rd = 65; t_ers = 80; t_rem = 93; t_clr = 96; end
    endcase
    r = $urandom_range(99);
    if (r < t_app)      fn = FN_APPEND;
    else if (r < t_ins) fn = FN_INSERT;
    else if (r < t_rd)  fn = FN_READ;
    else if (r < t_ers) fn = FN_ERASE;
    else if (r < t_rem) fn = FN_REMOVE;
    else if (r < t_clr) fn = FN_CLEAR;
    else fn = $urandom_range(1) ? FN_SPARE_HI : FN_SPARE_LO;

    pos = POS_BITS'($urandom_range(LIST_DEPTH - 1));
    if ($urandom_range(99) < 85) begin
      if (fn == FN_INSERT && tracker.used < LIST_DEPTH - 1)
        pos = POS_BITS'($urandom_range(tracker.used));
      else if ((fn == FN_ERASE || fn == FN_READ) && tracker.used > 0)
        pos = POS_BITS'($urandom_range(tracker.used - 1));
    end

    case ($urandom_range(7))
      0: val = 32'h8000_0000;
      1: val = 32'h7fff_ffff;
      2: val = '0;
      3: val = '1;
      default: val = $urandom;
    endcase
    return {7'd0, val, pos, fn};
  endfunction

  initial begin
    int n, dwell;
    mix_mode_t mode;
    dwell = 0;
    mode = MODE_GROW;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list rejections, insert index limits, extreme words
    send_op(FN_READ,   6'd0,  32'h0);
    send_op(FN_REMOVE, 6'd0,  32'h0);
    send_op(FN_ERASE,  6'd0,  32'h0);
    send_op(FN_INSERT, 6'd1,  32'h1);
    send_op(FN_INSERT, 6'd0,  32'h7fff_ffff);
    send_op(FN_APPEND, 6'd63, 32'h8000_0000);
    send_op(FN_APPEND, 6'd0,  32'h0);
    send_op(FN_APPEND, 6'd0,  32'hffff_ffff);
    send_op(FN_INSERT, 6'd4,  32'h1234_5678);
    send_op(FN_INSERT, 6'd2,  32'h5555_5555);
    send_op(FN_INSERT, 6'd63, 32'haaaa_aaaa);
    send_op(FN_READ,   6'd0,  32'h0);
    send_op(FN_READ,   6'd5,  32'h0);
    send_op(FN_READ,   6'd6,  32'h0);
    send_op(FN_READ,   6'd63, 32'hffff_ffff);
    send_op(FN_ERASE,  6'd6,  32'h0);
    send_op(FN_ERASE,  6'd0,  32'h0);
    send_op(FN_ERASE,  6'd4,  32'h0);
    send_op(FN_READ,   6'd2,  32'h0);
    send_op(FN_SPARE_LO, 6'd63, 32'hffff_ffff);
    send_op(FN_SPARE_HI, 6'd0,  32'h8000_0000);
    send_op(FN_REMOVE, 6'd0,  32'h0);
    send_op(FN_CLEAR,  6'd0,  32'h0);
    send_op(FN_READ,   6'd0,  32'h0);
    drain_replies();

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % (RANDOM_ITEMS / 4) == 0) begin
        drain_replies();
        case (n / (RANDOM_ITEMS / 4))
          0:       begin send_idle = 0;  recv_stall = 0;  end
          1:       begin send_idle = 55; recv_stall = 0;  end
          2:       begin send_idle = 0;  recv_stall = 55; end
          default: begin send_idle = 14; recv_stall = 14; end
        endcase
      end
      if (n == 40) hold_req = 1'b1;
      case (mode)
        MODE_GROW: begin
          if (tracker.used == LIST_DEPTH) dwell++;
          if (dwell >= 10) begin
            mode = MODE_SHRINK;
            dwell = 0;
          end
        end
        MODE_SHRINK: begin
          if (tracker.used == 0) dwell++;
          if (dwell >= 4) begin
            mode = MODE_MIXED;
            dwell = 0;
          end
        end
        default: begin
          dwell++;
          if (dwell >= 60) begin
            mode = MODE_GROW;
            dwell = 0;
          end
        end
      endcase
      send_item(pick_item(mode));
    end
    s_tvalid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d results over append/remove/insert/erase/read/clear and spare codes",
             tracker.n_checked);
    $display("Peak fill %0d of %0d; full rejects %0d, empty rejects %0d, bad index %0d",
             tracker.peak_used, LIST_DEPTH, tracker.n_full, tracker.n_empty, tracker.n_bad);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
